@@ hdl/internet_checksum_stream_top_macros.svh @@
// Assertion shorthands shared by the checksum RTL.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef INTERNET_CHECKSUM_STREAM_TOP_MACROS_SVH
`define INTERNET_CHECKSUM_STREAM_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ICS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define ICS_NEVER(lbl, cond, msg) \
    `ICS_ASSERT(lbl, !(cond), msg)

`endif

@@ hdl/ics_pkg.sv @@
package ics_pkg;

    localparam int unsigned SumW  = 32;
    localparam int unsigned WordW = 16;
    localparam int unsigned ByteW = 8;

    // Input beat after seed preparation.
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic [SumW-1:0]  start_sum;
        logic             first;
        logic             last;
        logic             odd_start;
    } t_item;

    // Accumulator state captured at the end of a message.
    typedef struct packed {
        logic [SumW-1:0]  sum;
        logic             high_phase;
        logic [ByteW-1:0] pend;
        logic             swap;
    } t_snap;

    // Add with end-around carry on 32 bits.
    function automatic logic [SumW-1:0] oc_add32(input logic [SumW-1:0] a,
                                                 input logic [SumW-1:0] b);
        logic [SumW:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[SumW-1:0] + {{(SumW-1){1'b0}}, t[SumW]};
    endfunction

    // Fold a 32-bit sum to 16 bits, two end-around steps.
    function automatic logic [WordW-1:0] fold16(input logic [SumW-1:0] s);
        logic [WordW:0] s1;
        logic [WordW:0] s2;
        s1 = {1'b0, s[SumW-1:WordW]} + {1'b0, s[WordW-1:0]};
        s2 = {1'b0, s1[WordW-1:0]} + {{WordW{1'b0}}, s1[WordW]};
        return s2[WordW-1:0];
    endfunction

    function automatic logic [WordW-1:0] swap16(input logic [WordW-1:0] v);
        return {v[ByteW-1:0], v[WordW-1:ByteW]};
    endfunction

endpackage

@@ hdl/internet_checksum_stream_top.sv @@
// Streaming one's-complement (RFC 1071 style) checksum. Message bytes arrive one per
// beat on the slave side; tuser[0] marks the first byte (the sum restarts from the seed
// in tdata[39:8]) and tuser[1] flags a message starting at an odd address; tlast marks
// the final byte, for which one 16-bit checksum beat leaves on the master side. Bytes
// pair into little-endian words. Throughput is one byte per clock unless a last byte
// waits for the finishing stages to free up; the 32-bit end-around-carry adder closes
// the running-sum loop. After its last byte is accepted, the checksum passes through
// the input register, accumulator capture, lone-byte add, then fold/swap/invert into
// the output register. Each stage frees itself when the next one can take its contents,
// so o_s_tready follows i_m_tready combinationally only when every stage is full.
module internet_checksum_stream_top
    import ics_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // data_byte [7:0], seed [39:8]
    input  logic        i_s_tlast,   // last_of_message
    input  logic [1:0]  i_s_tuser,   // first_of_message [0], odd_start [1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // checksum [15:0]
);

    logic  in_vld;
    t_item in_item;
    logic  in_take;
    logic  snap_vld;
    t_snap snap;
    logic  snap_take;

    ics_input u_input (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_vld      (in_vld),
        .o_item     (in_item),
        .i_take     (in_take)
    );

    ics_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (in_vld),
        .i_item      (in_item),
        .o_take      (in_take),
        .o_snap_vld  (snap_vld),
        .o_snap      (snap),
        .i_snap_take (snap_take)
    );

    ics_final u_final (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_vld  (snap_vld),
        .i_snap      (snap),
        .o_snap_take (snap_take),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

@@ hdl/ics_input.sv @@
module ics_input
    import ics_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // data_byte [7:0], seed [39:8]
    input  logic        i_s_tlast,
    input  logic [1:0]  i_s_tuser,   // first_of_message [0], odd_start [1]
    output logic        o_vld,
    output t_item       o_item,
    input  logic        i_take
);

    logic             r_vld;
    t_item            r_item;
    logic [SumW-1:0]  seed;
    logic [SumW-1:0]  start_sum;
    logic             odd;

    assign seed = i_s_tdata[ByteW +: SumW];
    assign odd  = i_s_tuser[1];

    // Prepare the start sum: odd starts take the seed raw, even starts fold and swap
    assign start_sum = odd ? seed : {{(SumW-WordW){1'b0}}, swap16(fold16(seed))};

    assign o_s_tready = !r_vld || i_take;
    assign o_vld      = r_vld;
    assign o_item     = r_item;

    // Hold the accepted beat until the accumulator takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item.data_byte <= i_s_tdata[ByteW-1:0];
            r_item.start_sum <= start_sum;
            r_item.first     <= i_s_tuser[0];
            r_item.last      <= i_s_tlast;
            r_item.odd_start <= odd;
        end
    end

endmodule

@@ hdl/ics_accum.sv @@
`include "internet_checksum_stream_top_macros.svh"

module ics_accum
    import ics_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_take,
    output logic  o_snap_vld,
    output t_snap o_snap,
    input  logic  i_snap_take
);

    logic [SumW-1:0]  r_sum;
    logic             r_phase;
    logic [ByteW-1:0] r_pend;
    logic             r_swap;
    logic             r_snap_vld;
    t_snap            r_snap;

    logic [SumW-1:0]  base_sum;
    logic             base_phase;
    logic [ByteW-1:0] base_pend;
    logic             base_swap;
    logic [SumW-1:0]  n_sum;
    logic             n_phase;
    logic [ByteW-1:0] n_pend;
    logic             snap_rdy;

    // Restart from the prepared seed on the first byte
    always_comb begin
        base_sum   = i_item.first ? i_item.start_sum : r_sum;
        base_phase = i_item.first ? i_item.odd_start : r_phase;
        base_pend  = i_item.first ? '0 : r_pend;
        base_swap  = i_item.first ? i_item.odd_start : r_swap;
    end

    // Pair bytes into little-endian words and add each completed word
    always_comb begin
        if (base_phase) begin
            n_sum   = oc_add32(base_sum, {{(SumW-WordW){1'b0}}, i_item.data_byte, base_pend});
            n_phase = 1'b0;
            n_pend  = '0;
        end else begin
            n_sum   = base_sum;
            n_phase = 1'b1;
            n_pend  = i_item.data_byte;
        end
    end

    assign snap_rdy   = !r_snap_vld || i_snap_take;
    assign o_take     = i_vld && (!i_item.last || snap_rdy);
    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

    // Advance the running state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_phase <= 1'b0;
            r_pend  <= '0;
            r_swap  <= 1'b0;
        end else if (o_take) begin
            if (i_item.last) begin
                r_sum   <= '0;
                r_phase <= 1'b0;
                r_pend  <= '0;
                r_swap  <= 1'b0;
            end else begin
                r_sum   <= n_sum;
                r_phase <= n_phase;
                r_pend  <= n_pend;
                r_swap  <= base_swap;
            end
        end
    end

    // Capture the end-of-message state for finishing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (o_take && i_item.last) begin
            r_snap_vld <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last) begin
            r_snap.sum        <= n_sum;
            r_snap.high_phase <= n_phase;
            r_snap.pend       <= n_pend;
            r_snap.swap       <= base_swap;
        end
    end

    `ICS_ASSERT(a_low_phase_no_pend, !r_phase |-> (r_pend == '0),
                "pending byte set outside the high phase")
    `ICS_ASSERT(a_last_clears, (o_take && i_item.last) |=> (r_sum == '0 && !r_phase && !r_swap),
                "state not cleared after last byte")
    `ICS_NEVER(a_snap_overrun, o_take && i_item.last && r_snap_vld && !i_snap_take,
               "end-of-message state overwritten before use")

endmodule

@@ hdl/ics_final.sv @@
module ics_final
    import ics_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_snap_vld,
    input  t_snap            i_snap,
    output logic             o_snap_take,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [WordW-1:0] o_m_tdata
);

    logic             r_fa_vld;
    logic [SumW-1:0]  r_fa_sum;
    logic             r_fa_swap;
    logic             r_out_vld;
    logic [WordW-1:0] r_out_data;

    logic             out_rdy;
    logic             fa_rdy;
    logic             fa_adv;
    logic [WordW-1:0] folded;
    logic [WordW-1:0] oriented;

    assign out_rdy     = !r_out_vld || i_m_tready;
    assign fa_adv      = r_fa_vld && out_rdy;
    assign fa_rdy      = !r_fa_vld || out_rdy;
    assign o_snap_take = i_snap_vld && fa_rdy;

    // Add a lone low byte left at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_vld <= 1'b0;
        end else if (o_snap_take) begin
            r_fa_vld <= 1'b1;
        end else if (fa_adv) begin
            r_fa_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_fa_sum  <= oc_add32(i_snap.sum, {{(SumW-ByteW){1'b0}},
                                  (i_snap.high_phase ? i_snap.pend : {ByteW{1'b0}})});
            r_fa_swap <= i_snap.swap;
        end
    end

    // Fold, swap for odd starts, invert
    assign folded   = fold16(r_fa_sum);
    assign oriented = r_fa_swap ? swap16(folded) : folded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fa_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fa_adv) begin
            r_out_data <= ~oriented;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule
